[design/skt_pkg.sv]
package skt_pkg;

	localparam int CAPACITY   = 32;
	localparam int NAME_BYTES = 16;
	localparam int MAX_OUT    = 32;
	localparam int DUMP_MAX   = (CAPACITY < MAX_OUT) ? CAPACITY : MAX_OUT;
	localparam int ADDR_W     = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	localparam logic [1:0] CMD_DUMP   = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;

	function automatic logic [63:0] byte_mask(input int nbytes);
		logic [63:0] m;
		m = '0;
		if (nbytes >= 8) begin
			m = '1;
		end else if (nbytes > 0) begin
			m = (64'd1 << (8 * nbytes)) - 64'd1;
		end
		return m;
	endfunction

	localparam logic [63:0] NAME_LOW_MASK  = byte_mask(NAME_BYTES);
	localparam logic [63:0] NAME_HIGH_MASK = byte_mask(NAME_BYTES - 8);

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] key;
		logic [63:0]        name_low;
		logic [63:0]        name_high;
		logic signed [31:0] score_in;
	} req_t;

	typedef struct packed {
		logic signed [31:0] out_key;
		logic [63:0]        out_name_low;
		logic [63:0]        out_name_high;
		logic signed [31:0] out_score;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] key;
		logic [63:0]        name_low;
		logic [63:0]        name_high;
		logic signed [31:0] score;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef struct packed {
		logic issue;
		logic last;
	} rd_tag_t;

endpackage

[design/sorted_key_table_unit.sv]
// Sorted record table: up to CAPACITY records of key, 16-byte name and score, kept in ascending
// signed key order in one record-wide RAM with a registered read. One command is taken at a time,
// and req_stall stays high until it has finished with the RAM. Insert scans from entry 0 up to its
// slot, reading and then checking each entry, then moves each later entry up one place (read,
// write); a duplicate key or a full table leaves the table unchanged. Delete scans the same way
// and closes the gap by moving each later entry down one place (read, write). Dump reads one
// record per cycle into a two-entry output queue while it has room and streams them at
// one transfer per cycle while rsp_stall is low; last marks the final record. An empty dump or an
// unused command code gives no transfer and leaves the controller idle, so req_stall stays low.
module sorted_key_table_unit
	import skt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic              room;
	rd_tag_t           rd_tag;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	rec_t              wr_rec;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [REC_W-1:0]  rd_data;
	rec_t              rd_rec;

	assign rd_rec = rec_t'(rd_data);

	skt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.room      (room),
		.rd_tag    (rd_tag),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_rec    (wr_rec),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_rec    (rd_rec)
	);

	skt_ram #(
		.WIDTH (REC_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (REC_W'(wr_rec)),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	skt_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_tag    (rd_tag),
		.rd_rec    (rd_rec),
		.room      (room),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

[design/skt_ram.sv]
module skt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[design/skt_ctrl.sv]
module skt_ctrl
	import skt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req,
	input  logic              room,
	output rd_tag_t           rd_tag,
	output logic              wr_en,
	output logic [ADDR_W-1:0] wr_addr,
	output rec_t              wr_rec,
	output logic              rd_en,
	output logic [ADDR_W-1:0] rd_addr,
	input  rec_t              rd_rec
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CHK,
		ST_INS_RD,
		ST_INS_WR,
		ST_DEL_RD,
		ST_DEL_WR,
		ST_DUMP
	} state_t;

	state_t           state_q;
	logic [1:0]       cmd_q;
	rec_t             new_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] count_q;

	logic [CNT_W-1:0] idx_m1;
	logic [CNT_W-1:0] idx_p1;
	logic [CNT_W-1:0] dump_n;
	logic             dump_last;

	assign idx_m1    = idx_q - 1'b1;
	assign idx_p1    = idx_q + 1'b1;
	assign dump_n    = (count_q > CNT_W'(DUMP_MAX)) ? CNT_W'(DUMP_MAX) : count_q;
	assign dump_last = (idx_p1 == dump_n);
	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q[ADDR_W-1:0];
		wr_rec  = rd_rec;
		rd_en   = 1'b0;
		rd_addr = idx_q[ADDR_W-1:0];
		rd_tag  = '0;
		case (state_q)
			ST_SRCH_RD: begin
				rd_en = (idx_q != count_q);
			end
			ST_INS_RD: begin
				if (idx_q != pos_q) begin
					rd_en   = 1'b1;
					rd_addr = idx_m1[ADDR_W-1:0];
				end else begin
					wr_en   = 1'b1;
					wr_addr = pos_q[ADDR_W-1:0];
					wr_rec  = new_q;
				end
			end
			ST_INS_WR: begin
				wr_en = 1'b1;
			end
			ST_DEL_RD: begin
				rd_en = (idx_q != count_q);
			end
			ST_DEL_WR: begin
				wr_en   = 1'b1;
				wr_addr = idx_m1[ADDR_W-1:0];
			end
			ST_DUMP: begin
				rd_en        = room;
				rd_tag.issue = room;
				rd_tag.last  = dump_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= CMD_DUMP;
			new_q   <= '0;
			idx_q   <= '0;
			pos_q   <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						cmd_q              <= req.command;
						new_q.key          <= req.key;
						new_q.name_low     <= req.name_low & NAME_LOW_MASK;
						new_q.name_high    <= req.name_high & NAME_HIGH_MASK;
						new_q.score        <= req.score_in;
						idx_q              <= '0;
						case (req.command)
							CMD_DUMP: begin
								if (count_q != '0) begin
									state_q <= ST_DUMP;
								end
							end
							CMD_INSERT: begin
								if (count_q != CNT_W'(CAPACITY)) begin
									state_q <= ST_SRCH_RD;
								end
							end
							CMD_DELETE: begin
								state_q <= ST_SRCH_RD;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SRCH_RD: begin
					if (idx_q == count_q) begin
						if (cmd_q == CMD_INSERT) begin
							pos_q   <= count_q;
							state_q <= ST_INS_RD;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_SRCH_CHK;
					end
				end
				ST_SRCH_CHK: begin
					if (rd_rec.key == new_q.key) begin
						if (cmd_q == CMD_DELETE) begin
							idx_q   <= idx_p1;
							state_q <= ST_DEL_RD;
						end else begin
							state_q <= ST_IDLE;
						end
					end else if (cmd_q == CMD_INSERT && rd_rec.key > new_q.key) begin
						pos_q   <= idx_q;
						idx_q   <= count_q;
						state_q <= ST_INS_RD;
					end else begin
						idx_q   <= idx_p1;
						state_q <= ST_SRCH_RD;
					end
				end
				ST_INS_RD: begin
					if (idx_q == pos_q) begin
						count_q <= count_q + 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_INS_WR;
					end
				end
				ST_INS_WR: begin
					idx_q   <= idx_m1;
					state_q <= ST_INS_RD;
				end
				ST_DEL_RD: begin
					if (idx_q == count_q) begin
						count_q <= count_q - 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DEL_WR;
					end
				end
				ST_DEL_WR: begin
					idx_q   <= idx_p1;
					state_q <= ST_DEL_RD;
				end
				ST_DUMP: begin
					if (room) begin
						if (dump_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_p1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[design/skt_outq.sv]
module skt_outq
	import skt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  rd_tag_t rd_tag,
	input  rec_t    rd_rec,
	output logic    room,
	output logic    rsp_valid,
	input  logic    rsp_stall,
	output rsp_t    rsp
);

	logic inflight_q;
	logic inflight_last_q;
	logic out_valid_q;
	logic skid_valid_q;
	rsp_t out_q;
	rsp_t skid_q;

	logic       pop;
	logic [1:0] occ;
	rsp_t       arr;

	assign pop  = out_valid_q & ~rsp_stall;
	assign occ  = {1'b0, out_valid_q} + {1'b0, skid_valid_q} + {1'b0, inflight_q};
	assign room = (occ - {1'b0, pop}) < 2'd2;

	assign arr.out_key       = rd_rec.key;
	assign arr.out_name_low  = rd_rec.name_low;
	assign arr.out_name_high = rd_rec.name_high;
	assign arr.out_score     = rd_rec.score;
	assign arr.last          = inflight_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q      <= 1'b0;
			inflight_last_q <= 1'b0;
			out_valid_q     <= 1'b0;
			skid_valid_q    <= 1'b0;
		end else begin
			inflight_q      <= rd_tag.issue;
			inflight_last_q <= rd_tag.last;
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= inflight_q;
				end else begin
					out_valid_q <= inflight_q;
				end
			end else if (!out_valid_q) begin
				out_valid_q <= inflight_q;
			end else if (inflight_q) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				skid_q <= arr;
			end else begin
				out_q <= arr;
			end
		end else if (!out_valid_q) begin
			out_q <= arr;
		end else if (inflight_q) begin
			skid_q <= arr;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

[design/skt_checker.sv]
module skt_checker
	import skt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	logic               in_dump_q;
	logic signed [31:0] prev_key_q;
	logic               rsp_xfer;

	assign rsp_xfer = rsp_valid & ~rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_dump_q  <= 1'b0;
			prev_key_q <= '0;
		end else if (rsp_xfer) begin
			in_dump_q  <= ~rsp.last;
			prev_key_q <= rsp.out_key;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	a_delete_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.command == CMD_DELETE |=> req_stall)
		else $error("delete did not occupy the table");

	a_dump_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_xfer && in_dump_q |-> rsp.out_key > prev_key_q)
		else $error("dump records not in ascending key order");

endmodule

bind sorted_key_table_unit skt_checker u_skt_checker (.*);

[verif/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import skt_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
	localparam logic [63:0]        ONES64  = {64{1'b1}};

	localparam int LOW_BYTES  = (NAME_BYTES >= 8) ? 8 : NAME_BYTES;
	localparam int HIGH_BYTES = (NAME_BYTES >= 16) ? 8 : ((NAME_BYTES > 8) ? NAME_BYTES - 8 : 0);
	localparam logic [63:0] LOW_KEEP  = (64'd1 << (8 * LOW_BYTES)) - 64'd1;
	localparam logic [63:0] HIGH_KEEP = (64'd1 << (8 * HIGH_BYTES)) - 64'd1;

	localparam int RANDOM_ITEMS = 410;
	localparam int HOLD_AT      = 80;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 4 * CAPACITY + 40;

	typedef struct {
		req_t item;
		bit   pinned;
		int   pin_count;
		rsp_t pin_rec;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	rec_t      shadow_table [CAPACITY];
	int        shadow_count;
	rsp_t      pending_records [$];
	plan_row_t plan [$];
	int        errors;
	int        sent_total;
	int        results_seen;

	sorted_key_table_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("%0t: timeout, %0d records still pending", $time, pending_records.size());
		$display("*** FAILED ***");
		$finish;
	end

	function automatic void apply_command(input req_t item, input bit emit);
		int   pos;
		int   j;
		int   n;
		bit   dup;
		rsp_t rec;
		pos = 0;
		dup = 1'b0;
		case (item.command)
			CMD_INSERT: begin
				while (pos < shadow_count && !dup &&
						$signed(shadow_table[pos].key) <= $signed(item.key)) begin
					if (shadow_table[pos].key == item.key) begin
						dup = 1'b1;
					end else begin
						pos++;
					end
				end
				if (!dup && shadow_count < CAPACITY) begin
					for (j = shadow_count; j > pos; j--) begin
						shadow_table[j] = shadow_table[j - 1];
					end
					shadow_table[pos].key       = item.key;
					shadow_table[pos].name_low  = item.name_low & LOW_KEEP;
					shadow_table[pos].name_high = item.name_high & HIGH_KEEP;
					shadow_table[pos].score     = item.score_in;
					shadow_count++;
				end
			end
			CMD_DELETE: begin
				while (pos < shadow_count && shadow_table[pos].key != item.key) begin
					pos++;
				end
				if (pos < shadow_count) begin
					for (j = pos + 1; j < shadow_count; j++) begin
						shadow_table[j - 1] = shadow_table[j];
					end
					shadow_count--;
				end
			end
			CMD_DUMP: begin
				n = (shadow_count < MAX_OUT) ? shadow_count : MAX_OUT;
				for (j = 0; j < n && emit; j++) begin
					rec.out_key       = shadow_table[j].key;
					rec.out_name_low  = shadow_table[j].name_low;
					rec.out_name_high = shadow_table[j].name_high;
					rec.out_score     = shadow_table[j].score;
					rec.last          = (j == n - 1);
					pending_records.push_back(rec);
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic logic signed [31:0] pick_key(input int hit_pct, input int pool_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < hit_pct && shadow_count > 0) begin
			return shadow_table[$urandom_range(0, shadow_count - 1)].key;
		end
		if (r < hit_pct + pool_pct) begin
			return $urandom_range(0, 40) - 20;
		end
		if (r < hit_pct + pool_pct + 5) begin
			return r[0] ? KEY_MIN : KEY_MAX;
		end
		return $urandom;
	endfunction

	function automatic logic [63:0] random_name();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return '0;
		end
		if (r == 1) begin
			return ONES64;
		end
		return {$urandom, $urandom};
	endfunction

	task automatic send_item(input req_t item);
		int gap;
		gap = ((sent_total % 64) < 48) ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sent_total++;
	endtask

	task automatic note_field(input string field, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, field, want, got);
			errors++;
		end
	endtask

	initial begin : rsp_side
		int   wait_n;
		rsp_t want;
		wait_n = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				results_seen++;
				if (pending_records.size() == 0) begin
					$display("%0t: unexpected transfer, key %h", $time, rsp.out_key);
					errors++;
				end else begin
					want = pending_records.pop_front();
					note_field("out_key", 64'(want.out_key), 64'(rsp.out_key));
					note_field("out_name_low", want.out_name_low, rsp.out_name_low);
					note_field("out_name_high", want.out_name_high, rsp.out_name_high);
					note_field("out_score", 64'(want.out_score), 64'(rsp.out_score));
					note_field("last", 64'(want.last), 64'(rsp.last));
				end
				wait_n = ((results_seen % 80) < 60) ? $urandom_range(0, 5) : 0;
				if (results_seen == HOLD_AT) begin
					wait_n = HOLD_CYCLES;
				end
			end else if (wait_n > 0) begin
				wait_n--;
			end
			rsp_stall <= (wait_n > 0);
		end
	end

	initial begin
		req_t item;
		rsp_t only_rec;
		int   counted;
		int   phase;
		int   r;
		int   hit;

		arst_n     <= 1'b0;
		req_valid  <= 1'b0;
		req        <= '0;
		errors       = 0;
		sent_total   = 0;
		results_seen = 0;
		shadow_count = 0;
		counted      = 0;

		only_rec = '{KEY_MIN, ONES64 & LOW_KEEP, ONES64 & HIGH_KEEP, KEY_MAX, 1'b1};

		plan.push_back('{'{CMD_DUMP, 32'sd0, 64'd0, 64'd0, 32'sd0}, 1'b1, 0, '0});
		plan.push_back('{'{CMD_UNUSED, 32'sd7, ONES64, ONES64, 32'sd5}, 1'b1, 0, '0});
		plan.push_back('{'{CMD_DELETE, 32'sd7, 64'd0, 64'd0, 32'sd0}, 1'b0, 0, '0});
		plan.push_back('{'{CMD_INSERT, KEY_MIN, ONES64, ONES64, KEY_MAX}, 1'b0, 0, '0});
		plan.push_back('{'{CMD_DUMP, 32'sd0, 64'd0, 64'd0, 32'sd0}, 1'b1, 1, only_rec});
		plan.push_back('{'{CMD_INSERT, KEY_MIN, 64'd0, 64'd0, 32'sd0}, 1'b0, 0, '0});
		plan.push_back('{'{CMD_DUMP, 32'sd0, 64'd0, 64'd0, 32'sd0}, 1'b1, 1, only_rec});
		plan.push_back('{'{CMD_INSERT, KEY_MAX, 64'd0, 64'd0, KEY_MIN}, 1'b0, 0, '0});
		plan.push_back('{'{CMD_INSERT, 32'sd0, 64'h0123_4567_89AB_CDEF,
				64'hFEDC_BA98_7654_3210, -32'sd1}, 1'b0, 0, '0});
		plan.push_back('{'{CMD_INSERT, -32'sd1, 64'h5555_5555_5555_5555,
				64'hAAAA_AAAA_AAAA_AAAA, 32'sd1}, 1'b0, 0, '0});
		plan.push_back('{'{CMD_INSERT, 32'sd1, 64'hAAAA_AAAA_AAAA_AAAA,
				64'h5555_5555_5555_5555, 32'sd0}, 1'b0, 0, '0});
		plan.push_back('{'{CMD_UNUSED, KEY_MAX, ONES64, ONES64, KEY_MAX}, 1'b1, 0, '0});
		plan.push_back('{'{CMD_DUMP, KEY_MIN, 64'd0, 64'd0, 32'sd0}, 1'b0, 0, '0});
		plan.push_back('{'{CMD_DELETE, 32'sd0, 64'd0, 64'd0, 32'sd0}, 1'b0, 0, '0});
		plan.push_back('{'{CMD_DELETE, KEY_MIN, 64'd0, 64'd0, 32'sd0}, 1'b0, 0, '0});
		plan.push_back('{'{CMD_DELETE, KEY_MAX, 64'd0, 64'd0, 32'sd0}, 1'b0, 0, '0});
		plan.push_back('{'{CMD_DELETE, 32'sd12345, 64'd0, 64'd0, 32'sd0}, 1'b0, 0, '0});
		plan.push_back('{'{CMD_DUMP, 32'sd0, 64'd0, 64'd0, 32'sd0}, 1'b0, 0, '0});
		plan.push_back('{'{CMD_DELETE, -32'sd1, 64'd0, 64'd0, 32'sd0}, 1'b0, 0, '0});
		plan.push_back('{'{CMD_DELETE, 32'sd1, 64'd0, 64'd0, 32'sd0}, 1'b0, 0, '0});
		plan.push_back('{'{CMD_DUMP, 32'sd0, 64'd0, 64'd0, 32'sd0}, 1'b1, 0, '0});
		plan.push_back('{'{CMD_INSERT, 32'sd42, 64'h0000_0000_6D65_7469,
				64'd0, 32'sd100}, 1'b0, 0, '0});
		plan.push_back('{'{CMD_DUMP, 32'sd0, 64'd0, 64'd0, 32'sd0}, 1'b0, 0, '0});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			send_item(plan[i].item);
			apply_command(plan[i].item, !plan[i].pinned);
			if (plan[i].pinned && plan[i].pin_count == 1) begin
				pending_records.push_back(plan[i].pin_rec);
			end
		end

		while (counted < RANDOM_ITEMS) begin
			phase = (counted / 50) % 4;
			r = $urandom_range(0, 99);
			case (phase)
				0: item.command = (r < 65) ? CMD_INSERT : (r < 80) ? CMD_DUMP :
						(r < 95) ? CMD_DELETE : CMD_UNUSED;
				1: item.command = (r < 85) ? CMD_INSERT : (r < 97) ? CMD_DUMP : CMD_UNUSED;
				2: item.command = (r < 60) ? CMD_DELETE : (r < 75) ? CMD_INSERT :
						(r < 95) ? CMD_DUMP : CMD_UNUSED;
				default: item.command = (r < 40) ? CMD_INSERT : (r < 65) ? CMD_DELETE :
						(r < 95) ? CMD_DUMP : CMD_UNUSED;
			endcase
			hit = (item.command == CMD_DELETE) ? 70 : ((phase == 1) ? 10 : 25);
			item.key       = pick_key(hit, (phase == 1) ? 20 : 45);
			item.name_low  = random_name();
			item.name_high = random_name();
			item.score_in  = $urandom;
			send_item(item);
			apply_command(item, 1'b1);
			if (item.command != CMD_UNUSED) begin
				counted++;
			end
		end
		req_valid <= 1'b0;

		while (pending_records.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[sorted_key_table_unit.f]
design/skt_pkg.sv
design/skt_ram.sv
design/skt_ctrl.sv
design/skt_outq.sv
design/sorted_key_table_unit.sv
design/skt_checker.sv
verif/testbench.sv
